### rtl/bev_pkg.sv
// Shared types, constants and helper functions of the button event and output switch.
`timescale 1ns / 1ps

package bev_pkg;

  // Width of the elapsed-time and auto-off counters.
  localparam int unsigned TimerBits = 16;

  typedef logic [TimerBits-1:0]    timer_t;
  typedef logic [TimerBits+15:0]   wide_t;

  localparam timer_t TimerMax = '1;

  // Configuration register indexes.
  localparam logic [1:0] RegSampleInterval = 2'd0;
  localparam logic [1:0] RegLongPressTime  = 2'd1;
  localparam logic [1:0] RegRelayInvert    = 2'd2;

  typedef enum logic [2:0] {
    CmdNone   = 3'd0,
    CmdOn     = 3'd1,
    CmdOff    = 3'd2,
    CmdToggle = 3'd3,
    CmdArm    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PhReleased = 2'd0,
    PhPressed  = 2'd1,
    PhLong     = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EvNone     = 2'd0,
    EvPressed  = 2'd1,
    EvReleased = 2'd2,
    EvLong     = 2'd3
  } event_e;

  typedef struct packed {
    logic [7:0]  sample_interval;
    logic [15:0] long_press_time;
    logic        relay_invert;
  } cfg_t;

  typedef struct packed {
    event_e event_res;
    logic   led_level;
    logic   relay_level;
    logic   is_on;
  } res_t;

  // Clamps a requested auto-off delay to the range of the timer.
  function automatic timer_t sat_delay(logic [15:0] delay);
    wide_t w;
    w = wide_t'(delay);
    if (w > wide_t'(TimerMax)) begin
      return TimerMax;
    end
    return timer_t'(delay);
  endfunction

  // True when the elapsed count exceeds the long press threshold.
  function automatic logic past_long(timer_t since, logic [15:0] limit);
    return wide_t'(since) > wide_t'(limit);
  endfunction

endpackage

### rtl/bev_core.sv
// Per-tick state update: command, button sampling, elapsed time and auto-off timer.
`timescale 1ns / 1ps

module bev_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                button_level_i,
  input  logic [2:0]          command_i,
  input  logic [15:0]         timeout_ticks_i,
  input  bev_pkg::cfg_t       cfg_i,
  output bev_pkg::res_t       res_o
);

  bev_pkg::phase_e phase_q, phase_d;
  logic [7:0]      wait_q, wait_d;
  bev_pkg::timer_t since_q, since_d;
  logic            on_q, on_d;
  logic            armed_q, armed_d;
  bev_pkg::timer_t left_q, left_d;
  bev_pkg::event_e ev;
  logic            just_armed;

  always_comb begin
    on_d       = on_q;
    armed_d    = armed_q;
    left_d     = left_q;
    just_armed = 1'b0;
    phase_d    = phase_q;
    ev         = bev_pkg::EvNone;

    case (bev_pkg::cmd_e'(command_i))
      bev_pkg::CmdOn:     on_d = 1'b1;
      bev_pkg::CmdOff:    on_d = 1'b0;
      bev_pkg::CmdToggle: on_d = ~on_q;
      bev_pkg::CmdArm: begin
        left_d     = bev_pkg::sat_delay(timeout_ticks_i);
        armed_d    = 1'b1;
        just_armed = 1'b1;
      end
      default: ;
    endcase

    since_d = (since_q != bev_pkg::TimerMax) ? since_q + 1'b1 : since_q;

    if (wait_q == 8'd0) begin
      if (!button_level_i && phase_q == bev_pkg::PhReleased) begin
        phase_d = bev_pkg::PhPressed;
        since_d = '0;
        ev      = bev_pkg::EvPressed;
      end else if (button_level_i && phase_q != bev_pkg::PhReleased) begin
        phase_d = bev_pkg::PhReleased;
        since_d = '0;
        ev      = bev_pkg::EvReleased;
      end else if (!button_level_i && phase_q == bev_pkg::PhPressed &&
                   bev_pkg::past_long(since_d, cfg_i.long_press_time)) begin
        phase_d = bev_pkg::PhLong;
        since_d = '0;
        ev      = bev_pkg::EvLong;
      end
      wait_d = cfg_i.sample_interval;
    end else begin
      wait_d = wait_q - 8'd1;
    end

    if (armed_q && !just_armed) begin
      if (left_q == '0) begin
        on_d    = 1'b0;
        armed_d = 1'b0;
      end else begin
        left_d = left_q - 1'b1;
      end
    end

    res_o.event_res   = ev;
    res_o.led_level   = on_d;
    res_o.relay_level = on_d ^ cfg_i.relay_invert;
    res_o.is_on       = on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bev_pkg::PhReleased;
      wait_q  <= '0;
      since_q <= '0;
      on_q    <= 1'b0;
      armed_q <= 1'b0;
      left_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      since_q <= since_d;
      on_q    <= on_d;
      armed_q <= armed_d;
      left_q  <= left_d;
    end
  end

endmodule

### rtl/bev_out_buf.sv
// Result register with a skid stage so the input side can take one more word under output stall.
`timescale 1ns / 1ps

module bev_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bev_pkg::res_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bev_pkg::res_t out_data_o
);

  logic          main_valid_q, skid_valid_q;
  bev_pkg::res_t main_q, skid_q;
  logic          pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= push_data_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

endmodule

### rtl/button_event_and_output_switch.sv
// Top level of the button event detector with switched output and auto-off timer.
`timescale 1ns / 1ps

// Each input word is one timer tick carrying the raw active-low button level and an
// optional command (on, off, toggle, or arm an auto-off delay); every accepted word
// yields exactly one result word with the button event, the LED level, the relay
// level and the switched-on state. The whole tick update is one pass of logic from
// the state registers into the result register, so one word is accepted per clock
// while the skid stage is free. A skid stage behind the result register lets the
// block keep taking words while a result waits; the input stalls only when both
// the result register and the skid stage are occupied. The button is sampled every
// sample_interval+1 ticks, and a long press is reported once the hold time exceeds
// long_press_time. Configuration registers are written through a plain write port
// and should only change while the block is idle.

module button_event_and_output_switch (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input words.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        button_level_i,
  input  logic [2:0]  command_i,
  input  logic [15:0] timeout_ticks_i,
  // Result words.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_res_o,
  output logic        led_level_o,
  output logic        relay_level_o,
  output logic        is_on_o
);

  bev_pkg::cfg_t cfg_q;
  bev_pkg::res_t res_next, res_out;
  logic          accept;
  logic          buf_full;

  // Configuration registers, reset to their documented defaults.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_interval <= 8'd10;
      cfg_q.long_press_time <= 16'd1000;
      cfg_q.relay_invert    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bev_pkg::RegSampleInterval: cfg_q.sample_interval <= cfg_data_i[7:0];
        bev_pkg::RegLongPressTime:  cfg_q.long_press_time <= cfg_data_i;
        bev_pkg::RegRelayInvert:    cfg_q.relay_invert    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A word is taken whenever the skid stage is free.
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  bev_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .button_level_i (button_level_i),
    .command_i      (command_i),
    .timeout_ticks_i(timeout_ticks_i),
    .cfg_i          (cfg_q),
    .res_o          (res_next)
  );

  bev_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res_next),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (res_out)
  );

  assign event_res_o   = res_out.event_res;
  assign led_level_o   = res_out.led_level;
  assign relay_level_o = res_out.relay_level;
  assign is_on_o       = res_out.is_on;

endmodule

### test/bev_result_checker.sv
// Checker that predicts every result word of the button event switch and compares it.
`timescale 1ns / 1ps

module bev_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        button_level_i,
  input  logic [2:0]  command_i,
  input  logic [15:0] timeout_ticks_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  event_res_i,
  input  logic        led_level_i,
  input  logic        relay_level_i,
  input  logic        is_on_i,
  output int          pending_o,
  output int          errors_o
);

  bev_pkg::cfg_t   cfg;
  bev_pkg::phase_e phase;
  logic [7:0]      sample_wait;
  bev_pkg::timer_t since_change;
  logic            switched_on;
  logic            auto_off_armed;
  bev_pkg::timer_t auto_off_left;
  bev_pkg::res_t   awaited_results[$];

  // One tick: command first, then the button sample, then the auto-off timer.
  function automatic bev_pkg::res_t advance_tick(logic level, logic [2:0] cmd,
                                                 logic [15:0] delay);
    bev_pkg::res_t   r;
    bev_pkg::event_e ev;
    logic            just_armed;
    ev = bev_pkg::EvNone;
    just_armed = 1'b0;
    case (cmd)
      bev_pkg::CmdOn:     switched_on = 1'b1;
      bev_pkg::CmdOff:    switched_on = 1'b0;
      bev_pkg::CmdToggle: switched_on = ~switched_on;
      bev_pkg::CmdArm: begin
        // Delays beyond the timer range stop at its largest count.
        if (delay > bev_pkg::TimerMax) begin
          auto_off_left = bev_pkg::TimerMax;
        end else begin
          auto_off_left = bev_pkg::timer_t'(delay);
        end
        auto_off_armed = 1'b1;
        just_armed     = 1'b1;
      end
      default: ;
    endcase
    if (since_change != bev_pkg::TimerMax) since_change = since_change + 1'b1;
    if (sample_wait == 8'd0) begin
      if (!level && phase == bev_pkg::PhReleased) begin
        phase        = bev_pkg::PhPressed;
        since_change = '0;
        ev           = bev_pkg::EvPressed;
      end else if (level && phase != bev_pkg::PhReleased) begin
        phase        = bev_pkg::PhReleased;
        since_change = '0;
        ev           = bev_pkg::EvReleased;
      end else if (!level && phase == bev_pkg::PhPressed &&
                   since_change > cfg.long_press_time) begin
        phase        = bev_pkg::PhLong;
        since_change = '0;
        ev           = bev_pkg::EvLong;
      end
      sample_wait = cfg.sample_interval;
    end else begin
      sample_wait = sample_wait - 8'd1;
    end
    if (auto_off_armed && !just_armed) begin
      if (auto_off_left == '0) begin
        switched_on    = 1'b0;
        auto_off_armed = 1'b0;
      end else begin
        auto_off_left = auto_off_left - 1'b1;
      end
    end
    r.event_res   = ev;
    r.led_level   = switched_on;
    r.relay_level = switched_on ^ cfg.relay_invert;
    r.is_on       = switched_on;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bev_pkg::res_t want;
    if (!rst_ni) begin
      cfg.sample_interval = 8'd10;
      cfg.long_press_time = 16'd1000;
      cfg.relay_invert    = 1'b0;
      phase               = bev_pkg::PhReleased;
      sample_wait         = '0;
      since_change        = '0;
      switched_on         = 1'b0;
      auto_off_armed      = 1'b0;
      auto_off_left       = '0;
      awaited_results.delete();
      pending_o           = 0;
      errors_o            = 0;
    end else begin
      // The result of a word is registered before it can show up, so results are
      // retired before this edge's input is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          errors_o++;
        end else begin
          want = awaited_results.pop_front();
          if (event_res_i !== want.event_res) begin
            $error("event_res mismatch: expected %0d, actual %0d", want.event_res, event_res_i);
            errors_o++;
          end
          if (led_level_i !== want.led_level) begin
            $error("led_level mismatch: expected %0d, actual %0d", want.led_level, led_level_i);
            errors_o++;
          end
          if (relay_level_i !== want.relay_level) begin
            $error("relay_level mismatch: expected %0d, actual %0d", want.relay_level,
                   relay_level_i);
            errors_o++;
          end
          if (is_on_i !== want.is_on) begin
            $error("is_on mismatch: expected %0d, actual %0d", want.is_on, is_on_i);
            errors_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bev_pkg::RegSampleInterval: cfg.sample_interval = cfg_data_i[7:0];
          bev_pkg::RegLongPressTime:  cfg.long_press_time = cfg_data_i;
          bev_pkg::RegRelayInvert:    cfg.relay_invert    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(advance_tick(button_level_i, command_i, timeout_ticks_i));
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

### test/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the button event switch.
`timescale 1ns / 1ps

module tb_top;

  // Hard stop for a hung handshake; far above the slowest legal run.
  localparam int CycleLimit   = 1000000;
  // Cycles the receiver refuses results in one go, so the skid stage fills up.
  localparam int RxHoldCycles = 200;
  // Quiet cycles after the last result before config writes and the verdict.
  localparam int DrainCycles  = 4;
  localparam int TailCycles   = 20;
  // Ticks of a held button under the widest interval and threshold.
  localparam int SoakTicks    = 30;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        button_level;
  logic [2:0]  command;
  logic [15:0] timeout_ticks;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  event_res;
  logic        led_level;
  logic        relay_level;
  logic        is_on;

  int pending;
  int errors;
  int cycle_count;

  // Idle pressure knobs, in percent; the stimulus retunes them per phase.
  int tx_gap_pct;
  int rx_stall_pct;
  bit rx_hold_req;

  // Current configuration as seen by the stimulus, used to size button runs.
  int cur_si;
  int cur_lp;

  button_event_and_output_switch u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .button_level_i  (button_level),
    .command_i       (command),
    .timeout_ticks_i (timeout_ticks),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .event_res_o     (event_res),
    .led_level_o     (led_level),
    .relay_level_o   (relay_level),
    .is_on_o         (is_on)
  );

  bev_result_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .button_level_i  (button_level),
    .command_i       (command),
    .timeout_ticks_i (timeout_ticks),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .event_res_i     (event_res),
    .led_level_i     (led_level),
    .relay_level_i   (relay_level),
    .is_on_i         (is_on),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog. Some waits in the stimulus are on a handshake, so a stuck block
  // would otherwise hang the run forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side. Stalls come in random bursts at a rate set by the current phase;
  // on request it also refuses results for a long fixed stretch so the sender
  // backs up against a full block.
  initial begin : result_sink
    int burst_left;
    burst_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (RxHoldCycles - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(14);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one tick word and returns at the edge where it is taken. A gap of
  // idle cycles may come first, depending on the phase.
  task automatic send_tick(logic level, logic [2:0] cmd, logic [15:0] delay);
    int gap;
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    button_level  <= level;
    command       <= cmd;
    timeout_ticks <= delay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering words and waits until every predicted result has come out.
  // Every word yields a result, so an empty queue means the block is idle; a
  // wait of DrainCycles quiet cycles follows anyway before anything else happens.
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Registers only change while the block is idle, so drain first.
  task automatic set_config(int si, int lp, logic inv);
    wait_results_done();
    write_reg(bev_pkg::RegSampleInterval, 16'(si));
    write_reg(bev_pkg::RegLongPressTime, 16'(lp));
    write_reg(bev_pkg::RegRelayInvert, {15'd0, inv});
    cur_si = si;
    cur_lp = lp;
  endtask

  // Random part of one phase. The button follows press and release runs whose
  // lengths scale with the current sample interval and long press threshold, so
  // that pressed, long pressed and released events all come up; a small share of
  // ticks carries a random level instead, which models contact bounce.
  task automatic run_phase(int n_items);
    logic        level;
    logic        pin;
    int          run_left;
    int          hold_span;
    int          pick;
    logic [2:0]  cmd;
    logic [15:0] delay;
    level    = 1'b1;
    run_left = 0;
    repeat (n_items) begin
      if (run_left == 0) begin
        level     = ~level;
        hold_span = level ? (cur_si * 2 + 10) : (cur_lp + cur_si * 3 + 30);
        if (hold_span > 400) hold_span = 400;
        run_left  = $urandom_range(1, hold_span);
      end
      run_left--;
      pin = ($urandom_range(99) < 8) ? 1'($urandom_range(1)) : level;
      // Delay bits are random on every word; only the arm command uses them.
      delay = 16'($urandom);
      pick  = $urandom_range(99);
      if (pick < 72) begin
        cmd = bev_pkg::CmdNone;
      end else if (pick < 78) begin
        cmd = bev_pkg::CmdOn;
      end else if (pick < 84) begin
        cmd = bev_pkg::CmdOff;
      end else if (pick < 90) begin
        cmd = bev_pkg::CmdToggle;
      end else if (pick < 97) begin
        cmd = bev_pkg::CmdArm;
        // Mostly short timeouts so that auto-off actually fires within the phase.
        if ($urandom_range(7) != 0) delay = 16'($urandom_range(0, 40));
      end else begin
        // Codes above the arm command must be ignored by the block.
        cmd = 3'($urandom_range(5, 7));
      end
      send_tick(pin, cmd, delay);
    end
  endtask

  initial begin : stimulus
    int p;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = bev_pkg::RegSampleInterval;
    cfg_data      = '0;
    in_valid      = 1'b0;
    button_level  = 1'b1;
    command       = bev_pkg::CmdNone;
    timeout_ticks = '0;
    tx_gap_pct    = 0;
    rx_stall_pct  = 0;
    rx_hold_req   = 1'b0;
    cycle_count   = 0;
    cur_si        = 10;
    cur_lp        = 1000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset configuration: switching commands while
    // the sampler waits out its first interval after the first word.
    send_tick(1'b1, bev_pkg::CmdNone, 16'h0000);
    send_tick(1'b0, bev_pkg::CmdOn, 16'hFFFF);
    send_tick(1'b0, bev_pkg::CmdToggle, 16'h0000);
    send_tick(1'b1, bev_pkg::CmdToggle, 16'hAAAA);

    // Sample every tick with a zero threshold and inverted relay: press, long
    // press on the very next tick, release, auto-off with a zero delay, a toggle
    // while armed, ignored codes, and the largest delay.
    set_config(0, 0, 1'b1);
    send_tick(1'b0, bev_pkg::CmdNone, 16'h0000);
    send_tick(1'b0, bev_pkg::CmdNone, 16'h0000);
    send_tick(1'b0, bev_pkg::CmdOn, 16'h0000);
    send_tick(1'b1, bev_pkg::CmdNone, 16'h0000);
    send_tick(1'b1, bev_pkg::CmdArm, 16'h0000);
    send_tick(1'b1, bev_pkg::CmdNone, 16'h0000);
    send_tick(1'b0, bev_pkg::CmdOn, 16'h0000);
    send_tick(1'b0, bev_pkg::CmdArm, 16'h0002);
    send_tick(1'b0, bev_pkg::CmdToggle, 16'h0000);
    send_tick(1'b0, bev_pkg::CmdToggle, 16'h0000);
    send_tick(1'b1, bev_pkg::CmdNone, 16'h0000);
    send_tick(1'b1, 3'd5, 16'h5555);
    send_tick(1'b0, 3'd6, 16'h0000);
    send_tick(1'b0, 3'd7, 16'hFFFF);
    send_tick(1'b1, bev_pkg::CmdArm, 16'hFFFF);
    send_tick(1'b1, bev_pkg::CmdOff, 16'h0000);

    // Short hold with the widest interval and threshold while the longest
    // auto-off delay is armed, then a release.
    set_config(255, 65534, 1'b0);
    send_tick(1'b0, bev_pkg::CmdOn, 16'h0000);
    send_tick(1'b0, bev_pkg::CmdArm, 16'hFFFF);
    repeat (SoakTicks) send_tick(1'b0, bev_pkg::CmdNone, 16'($urandom));
    send_tick(1'b1, bev_pkg::CmdNone, 16'h0000);

    // Random phases, each under its own configuration and idle pressure. Each
    // config change drains the block first, so the sender also pauses until
    // every result is out.
    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_config(0, 0, 1'b0);
        1: set_config(1, 3, 1'b1);
        2: set_config(3, 20, 1'b0);
        3: set_config(255, 65534, 1'b1);
        default: set_config($urandom_range(0, 7), $urandom_range(0, 60), 1'($urandom));
      endcase
      if (p == 7) begin
        // Final stretch runs flat out on both sides.
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else if (p == 2) begin
        // Sender keeps offering while the receiver holds off for a long time.
        tx_gap_pct   = 0;
        rx_stall_pct = 10;
        rx_hold_req  = 1'b1;
      end else begin
        tx_gap_pct   = (p % 3 == 0) ? 0 : 15;
        rx_stall_pct = (p % 3 == 1) ? 0 : 15;
      end
      run_phase(200);
    end

    wait_results_done();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
